@@ src/rpd_pkg.sv @@
// Shared types and constants for the palette RLE image decoder.
`default_nettype none

package rpd_pkg;

	localparam int REQ_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int COLOUR_W = 24;
	localparam int LEN_W    = 9;
	localparam int TOTAL_W  = 21;
	localparam int PSIZE_W  = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 21;
	localparam int MAX_RUNS = 4;
	localparam int RUN_CNT_W = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_WRITE = 2'd0,
		REQ_DATA  = 2'd1,
		REQ_START = 2'd2
	} req_t;

	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TOTAL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_FORMAT   = 2'd2;

	localparam logic [PSIZE_W-1:0] PSIZE_RESET  = 9'd256;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET  = 21'd76800;

	typedef enum logic [1:0] {
		PH_FLAG   = 2'd0,
		PH_REPEAT = 2'd1,
		PH_INDEX  = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  cnt;
		logic [7:0]  rep;
		logic [7:0]  idx;
	} parse_st_t;

	localparam parse_st_t PARSE_CLEAR = '{phase: PH_FLAG, cnt: 4'd0, rep: 8'd0, idx: 8'd0};

	typedef struct packed {
		logic [7:0] rep;
		logic [7:0] idx;
	} code_t;

	typedef struct packed {
		parse_st_t                  st;
		code_t [MAX_RUNS-1:0]       codes;
		logic [RUN_CNT_W-1:0]       n;
	} parse_res_t;

	// RGB888 {r,g,b} to 16-bit packed colour, red in the low bits
	function automatic logic [COLOUR_W-1:0] pack565(logic [COLOUR_W-1:0] e);
		return {8'd0, e[7:3], e[15:10], e[23:19]};
	endfunction

endpackage

`default_nettype wire

@@ src/rpd_req_if.sv @@
// Request channel: palette writes, image bytes and start requests.
`default_nettype none

interface rpd_req_if;
	import rpd_pkg::*;

	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [7:0]          entry_index;
	logic [7:0]          entry_red;
	logic [7:0]          entry_green;
	logic [7:0]          entry_blue;
	logic [BYTE_W-1:0]   data_byte;

	modport source (output valid, req_type, entry_index, entry_red, entry_green, entry_blue,
		data_byte, input ready);
	modport sink (input valid, req_type, entry_index, entry_red, entry_green, entry_blue,
		data_byte, output ready);
endinterface

`default_nettype wire

@@ src/rpd_run_if.sv @@
// Run channel: one decoded run per transaction.
`default_nettype none

interface rpd_run_if;
	import rpd_pkg::*;

	logic                valid;
	logic                ready;
	logic [COLOUR_W-1:0] run_colour;
	logic [LEN_W-1:0]    run_length;
	logic                last_of_byte;
	logic                image_done;
	logic                run_clipped;

	modport source (output valid, run_colour, run_length, last_of_byte, image_done, run_clipped,
		input ready);
	modport sink (input valid, run_colour, run_length, last_of_byte, image_done, run_clipped,
		output ready);
endinterface

`default_nettype wire

@@ src/rpd_cfg_if.sv @@
// Configuration write channel.
`default_nettype none

interface rpd_cfg_if;
	import rpd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/rle_palette_image_decoder_core.sv @@
// Palette RLE image decoder: byte parser, run issue stage and output register.
// Path: a byte waits in the request register, its codes in the code buffer, each run in
//   the output register. A byte gives at most 4 runs; the next request enters as its last
//   run issues. Runs issue one per cycle unless the output stalls, via the single read port.
// Reset: arst_n clears pipeline control, parse state and pixel count and loads the
//   register defaults; palette contents are undefined until written.
`default_nettype none

module rle_palette_image_decoder_core #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rpd_req_if.sink    req,
	rpd_run_if.source  run,
	rpd_cfg_if.sink    cfg
);
	import rpd_pkg::*;

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [PSIZE_W-1:0] PE9 = PSIZE_W'(PALETTE_ENTRIES);

	// ---------------- configuration ----------------
	logic [PSIZE_W-1:0]  palette_size_q;
	logic [TOTAL_W-1:0]  pixel_total_q;
	logic                out_format_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= PSIZE_RESET;
			pixel_total_q  <= TOTAL_RESET;
			out_format_q   <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_PALETTE_SIZE: palette_size_q <= cfg.data[PSIZE_W-1:0];
				CFG_PIXEL_TOTAL:  pixel_total_q  <= cfg.data[TOTAL_W-1:0];
				CFG_OUT_FORMAT:   out_format_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	function automatic logic [3:0] index_width(logic [PSIZE_W-1:0] ps);
		logic [PSIZE_W-1:0] n;
		logic [PSIZE_W-1:0] v;
		logic [3:0]         w;
		n = (ps == '0 || ps > PE9) ? PE9 : ps;
		v = (n > PSIZE_W'(1)) ? n - PSIZE_W'(1) : PSIZE_W'(1);
		w = 4'd0;
		for (int i = 0; i < PSIZE_W; i++) begin
			if (v[i]) w = 4'(i + 1);
		end
		return w;
	endfunction

	// whole byte, MSB first; codes come out in order
	function automatic parse_res_t parse_byte(parse_st_t st_in, logic [7:0] b, logic [3:0] w);
		parse_res_t r;
		logic       bv;
		r.st    = st_in;
		r.codes = '0;
		r.n     = '0;
		for (int j = 0; j < 8; j++) begin
			bv = b[7-j];
			case (r.st.phase)
				PH_FLAG: r.st.phase = bv ? PH_REPEAT : PH_INDEX;
				PH_REPEAT: begin
					r.st.rep = {r.st.rep[6:0], bv};
					r.st.cnt = r.st.cnt + 4'd1;
					if (r.st.cnt >= 4'd8) begin
						r.st.phase = PH_INDEX;
						r.st.cnt   = 4'd0;
					end
				end
				PH_INDEX: begin
					r.st.idx = {r.st.idx[6:0], bv};
					r.st.cnt = r.st.cnt + 4'd1;
					if (r.st.cnt >= w) begin
						r.codes[r.n[1:0]] = '{rep: r.st.rep, idx: r.st.idx};
						r.n  = r.n + RUN_CNT_W'(1);
						r.st = PARSE_CLEAR;
					end
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	// ---------------- stage 1: request register ----------------
	logic               valid_s1;
	logic [REQ_W-1:0]   req_type_s1;
	logic [7:0]         entry_index_s1;
	logic [COLOUR_W-1:0] entry_s1;
	logic [7:0]         data_byte_s1;

	// ---------------- stage 2: code buffer ----------------
	code_t [MAX_RUNS-1:0]  codes_s2;
	logic [RUN_CNT_W-1:0]  n_s2;

	// ---------------- stage 3: output register ----------------
	logic                valid_s3;
	logic [COLOUR_W-1:0] rd_s3;
	logic                oob_s3;
	logic [LEN_W-1:0]    len_s3;
	logic                last_s3;
	logic                done_s3;
	logic                clip_s3;

	parse_st_t           parse_q;
	parse_st_t           parse_d;
	logic [TOTAL_W-1:0]  pixels_done_q;

	logic [COLOUR_W-1:0] palette_mem [PALETTE_ENTRIES];

	logic               issue;
	logic               s2_free;
	logic               s1_adv;
	logic               is_data;
	logic               is_start;
	logic               is_write;
	logic               halted;
	logic               ge_total;
	parse_res_t         pres;

	logic [LEN_W-1:0]   len_raw;
	logic [TOTAL_W-1:0] remaining;
	logic               clip;
	logic               done;
	logic [LEN_W-1:0]   len_out;
	code_t              front;

	assign front     = codes_s2[0];
	assign issue     = (n_s2 != '0) && (!valid_s3 || run.ready);
	assign len_raw   = {1'b0, front.rep} + LEN_W'(1);
	assign remaining = pixel_total_q - pixels_done_q;
	assign clip      = TOTAL_W'(len_raw) > remaining;
	assign done      = clip || (TOTAL_W'(len_raw) == remaining);
	assign len_out   = clip ? remaining[LEN_W-1:0] : len_raw;

	assign s2_free   = (n_s2 == '0) || (issue && (n_s2 == RUN_CNT_W'(1) || done));
	assign s1_adv    = valid_s1 && s2_free;
	assign req.ready = !valid_s1 || s1_adv;

	assign is_data   = (req_type_s1 == REQ_DATA);
	assign is_start  = (req_type_s1 == REQ_START);
	assign is_write  = (req_type_s1 == REQ_WRITE);

	// the byte sees everything the previous byte's runs left, including a run ending now
	assign ge_total  = (pixels_done_q >= pixel_total_q);
	assign halted    = (parse_q.phase == PH_DONE) || ge_total || (issue && done);
	assign pres      = parse_byte(parse_q, data_byte_s1, index_width(palette_size_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1    <= req.req_type;
			entry_index_s1 <= req.entry_index;
			entry_s1       <= {req.entry_red, req.entry_green, req.entry_blue};
			data_byte_s1   <= req.data_byte;
		end
	end

	always_comb begin
		parse_d = parse_q;
		if (s1_adv && is_start) begin
			parse_d = PARSE_CLEAR;
		end else if (issue && done) begin
			parse_d       = PARSE_CLEAR;
			parse_d.phase = PH_DONE;
		end else if (s1_adv && is_data && !halted) begin
			parse_d = pres.st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q       <= PARSE_CLEAR;
			pixels_done_q <= '0;
			n_s2          <= '0;
		end else begin
			parse_q <= parse_d;
			if (s1_adv && is_start) begin
				pixels_done_q <= '0;
			end else if (issue) begin
				pixels_done_q <= pixels_done_q + TOTAL_W'(len_out);
			end
			if (s1_adv) begin
				n_s2 <= (is_data && !halted) ? pres.n : '0;
			end else if (issue) begin
				n_s2 <= done ? '0 : n_s2 - RUN_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			codes_s2 <= pres.codes;
		end else if (issue) begin
			codes_s2 <= {code_t'('0), codes_s2[MAX_RUNS-1:1]};
		end
	end

	// palette: one write port, one registered read port (read sees data before a same-edge write)
	always_ff @(posedge clk) begin
		if (s1_adv && is_write && ({1'b0, entry_index_s1} < PE9)) begin
			palette_mem[entry_index_s1[AW-1:0]] <= entry_s1;
		end
		if (issue) begin
			rd_s3 <= palette_mem[front.idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (issue) begin
			valid_s3 <= 1'b1;
		end else if (run.ready) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			oob_s3  <= ({1'b0, front.idx} >= PE9);
			len_s3  <= len_out;
			last_s3 <= (n_s2 == RUN_CNT_W'(1)) || done;
			done_s3 <= done;
			clip_s3 <= clip;
		end
	end

	assign run.valid        = valid_s3;
	assign run.run_colour   = oob_s3 ? '0 : (out_format_q ? pack565(rd_s3) : rd_s3);
	assign run.run_length   = len_s3;
	assign run.last_of_byte = last_s3;
	assign run.image_done   = done_s3;
	assign run.run_clipped  = clip_s3;

	// ---------------- assertions ----------------
	a_code_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_s2 <= RUN_CNT_W'(MAX_RUNS))
		else $error("code buffer holds more runs than one byte can give");

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && done) |=> (parse_q.phase == PH_DONE) || $past(s1_adv && is_start))
		else $error("parser not stopped after the final run");

	a_clip_done: assert property (@(posedge clk) disable iff (!arst_n)
		(run.valid && run.run_clipped) |-> run.image_done)
		else $error("clipped run without image done");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(run.valid && run.image_done) |-> run.last_of_byte)
		else $error("final run not marked last of byte");

endmodule

`default_nettype wire

@@ bench/tb_rle_palette_image_decoder_core.sv @@
// Self-checking bench for the palette RLE decoder: palette fill, directed table, then random images.
`default_nettype none

module tb_rle_palette_image_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rpd_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 400;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 14;
	localparam int HOLD_PHASE   = 5;
	localparam int MAX_SHOWN    = 10;

	// encoding the block leaves unused; it must be dropped
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic [7:0]        slot;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [BYTE_W-1:0] dbyte;
	} req_item_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] colour;
		logic [LEN_W-1:0]    run_len;
		logic                last_of_byte;
		logic                image_done;
		logic                clipped;
	} run_t;

	typedef struct {
		bit                    is_setting;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		req_item_t             item;
		bit                    typed;
		run_t                  want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	rpd_req_if req_bus();
	rpd_run_if run_bus();
	rpd_cfg_if cfg_bus();

	rle_palette_image_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.run    (run_bus),
		.cfg    (cfg_bus)
	);

	always #6 clk = ~clk;

	// decoder state mirrored by the bench
	logic [PSIZE_W-1:0]   psize_reg;
	logic [TOTAL_W-1:0]   total_reg;
	logic                 fmt_reg;
	phase_t               parse_ph;
	logic [3:0]           bit_cnt;
	logic [7:0]           rep_acc;
	logic [7:0]           idx_acc;
	logic [TOTAL_W-1:0]   px_done;
	logic [COLOUR_W-1:0]  colour_table [256];

	run_t     byte_runs[$];
	run_t     pending_runs[$];
	dir_row_t directed[$];
	run_t     no_run = '0;

	bit send_burst;
	bit take_burst;
	bit long_hold_req;
	bit stream_dirty;
	bit cfg_held;

	int fail_count;
	int cycle_count;
	int items_sent;
	int bytes_sent;
	int writes_sent;
	int settings_written;
	int runs_checked;
	int runs_clipped;
	int images_done;

	// Walks one request through the parser and collects the runs it yields.
	function automatic void decode_request(input req_item_t it);
		logic [8:0]          n;
		logic [8:0]          v;
		logic [3:0]          width;
		logic                bitv;
		logic [31:0]         len;
		logic [31:0]         remaining;
		logic [COLOUR_W-1:0] entry;
		logic [7:0]          red, grn, blu;
		run_t                r;
		byte_runs.delete();
		case (it.kind)
			REQ_WRITE: colour_table[it.slot] = {it.red, it.green, it.blue};
			REQ_START: begin
				parse_ph = PH_FLAG;
				bit_cnt = 4'd0;
				rep_acc = 8'd0;
				idx_acc = 8'd0;
				px_done = '0;
			end
			REQ_DATA: begin
				n = psize_reg;
				if (n == 9'd0 || n > 9'd256) n = 9'd256;
				v = (n > 9'd1) ? n - 9'd1 : 9'd1;
				width = 4'd0;
				while (v != 9'd0) begin
					width = width + 4'd1;
					v = v >> 1;
				end
				for (int j = 7; j >= 0; j--) begin
					bitv = it.dbyte[j];
					// once the image is complete nothing moves until a start
					if (parse_ph != PH_DONE && px_done < total_reg) begin
						if (parse_ph == PH_FLAG) begin
							if (bitv) parse_ph = PH_REPEAT;
							else parse_ph = PH_INDEX;
						end else if (parse_ph == PH_REPEAT) begin
							rep_acc = {rep_acc[6:0], bitv};
							bit_cnt = bit_cnt + 4'd1;
							if (bit_cnt >= 4'd8) begin
								parse_ph = PH_INDEX;
								bit_cnt = 4'd0;
							end
						end else begin
							idx_acc = {idx_acc[6:0], bitv};
							bit_cnt = bit_cnt + 4'd1;
							// also fires when a narrower index width was set mid-code
							if (bit_cnt >= width) begin
								len = {24'd0, rep_acc} + 32'd1;
								remaining = {11'd0, total_reg} - {11'd0, px_done};
								r.clipped = 1'b0;
								if (len > remaining) begin
									len = remaining;
									r.clipped = 1'b1;
								end
								px_done = px_done + len[TOTAL_W-1:0];
								r.image_done = (len == remaining);
								entry = colour_table[idx_acc];
								red = entry[23:16];
								grn = entry[15:8];
								blu = entry[7:0];
								if (fmt_reg) r.colour = {8'h00, blu[7:3], grn[7:2], red[7:3]};
								else r.colour = entry;
								r.run_len = len[LEN_W-1:0];
								r.last_of_byte = 1'b0;
								byte_runs.push_back(r);
								parse_ph = r.image_done ? PH_DONE : PH_FLAG;
								bit_cnt = 4'd0;
								rep_acc = 8'd0;
								idx_acc = 8'd0;
							end
						end
					end
				end
				if (byte_runs.size() > 0) byte_runs[byte_runs.size()-1].last_of_byte = 1'b1;
			end
			default: ;
		endcase
	endfunction

	function automatic dir_row_t setting_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		dir_row_t row;
		row = '{default: '0};
		row.is_setting = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	function automatic dir_row_t request_row(input logic [REQ_W-1:0] kind,
			input logic [7:0] slot, input logic [23:0] rgb, input logic [7:0] dbyte);
		dir_row_t row;
		row = '{default: '0};
		row.item.kind = kind;
		row.item.slot = slot;
		row.item.red = rgb[23:16];
		row.item.green = rgb[15:8];
		row.item.blue = rgb[7:0];
		row.item.dbyte = dbyte;
		return row;
	endfunction

	// single-run row whose result is plain from the bits
	function automatic dir_row_t typed_row(input dir_row_t row, input logic [23:0] colour,
			input logic [8:0] len, input bit image_done, input bit clipped);
		row.typed = 1'b1;
		row.want = '{colour: colour, run_len: len, last_of_byte: 1'b1,
			image_done: image_done, clipped: clipped};
		return row;
	endfunction

	task automatic wait_idle();
		req_bus.valid <= 1'b0;
		if (cfg_held) begin
			cfg_bus.valid <= 1'b0;
			cfg_held = 1'b0;
		end
		while (pending_runs.size() != 0) @(posedge clk);
		// a request with no run may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
		stream_dirty = 1'b0;
	endtask

	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		if (stream_dirty) wait_idle();
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		cfg_held = 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			CFG_PALETTE_SIZE: psize_reg = val[PSIZE_W-1:0];
			CFG_PIXEL_TOTAL:  total_reg = val[TOTAL_W-1:0];
			CFG_OUT_FORMAT:   fmt_reg = val[0];
			default: ;
		endcase
		settings_written++;
	endtask

	task automatic send_req(input req_item_t it, input bit typed, input run_t want);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 18);
		if (cfg_held) begin
			cfg_bus.valid <= 1'b0;
			cfg_held = 1'b0;
		end
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.req_type <= it.kind;
		req_bus.entry_index <= it.slot;
		req_bus.entry_red <= it.red;
		req_bus.entry_green <= it.green;
		req_bus.entry_blue <= it.blue;
		req_bus.data_byte <= it.dbyte;
		do @(posedge clk); while (!req_bus.ready);
		decode_request(it);
		if (typed) pending_runs.push_back(want);
		else foreach (byte_runs[k]) pending_runs.push_back(byte_runs[k]);
		stream_dirty = 1'b1;
		items_sent++;
		if (it.kind == REQ_DATA) bytes_sent++;
		if (it.kind == REQ_WRITE) writes_sent++;
	endtask

	task automatic random_item(output req_item_t it);
		logic [31:0] rnd_a;
		logic [31:0] rnd_b;
		int unsigned pick;
		rnd_a = $urandom();
		rnd_b = $urandom();
		it.slot = rnd_a[7:0];
		it.red = rnd_a[15:8];
		it.green = rnd_a[23:16];
		it.blue = rnd_a[31:24];
		it.dbyte = rnd_b[7:0];
		pick = $urandom_range(0, 99);
		if (pick < 78) it.kind = REQ_DATA;
		else if (pick < 88) it.kind = REQ_WRITE;
		else if (pick < 94) it.kind = REQ_START;
		else it.kind = REQ_UNUSED;
	endtask

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d runs still expected",
			cycle_count, pending_runs.size());
		$display("rle_palette_image_decoder_core regression: fail");
		$finish;
	end

	initial begin : run_sink
		int   stall;
		run_t got;
		run_t want;
		run_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold_req) begin
				stall = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				stall = take_burst ? 0 : $urandom_range(0, 18);
			end
			if ($urandom_range(0, 24) == 0) take_burst = !take_burst;
			if (stall > 0) begin
				run_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			run_bus.ready <= 1'b1;
			do @(posedge clk); while (!run_bus.valid);
			got = '{colour: run_bus.run_colour, run_len: run_bus.run_length,
				last_of_byte: run_bus.last_of_byte, image_done: run_bus.image_done,
				clipped: run_bus.run_clipped};
			if (pending_runs.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_SHOWN)
					$display("unexpected run: colour %h len %0d last %0b done %0b clip %0b",
						got.colour, got.run_len, got.last_of_byte, got.image_done,
						got.clipped);
			end else begin
				want = pending_runs.pop_front();
				runs_checked++;
				if (want.clipped) runs_clipped++;
				if (want.image_done) images_done++;
				if (got !== want) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN) begin
						$display("run %0d mismatch at cycle %0d", runs_checked, cycle_count);
						$display("  expected colour %h len %0d last %0b done %0b clip %0b",
							want.colour, want.run_len, want.last_of_byte,
							want.image_done, want.clipped);
						$display("  actual   colour %h len %0d last %0b done %0b clip %0b",
							got.colour, got.run_len, got.last_of_byte,
							got.image_done, got.clipped);
					end
				end
			end
		end
	end

	initial begin : stimulus
		req_item_t   it;
		logic [31:0] rnd;
		logic [CFG_DATA_W-1:0] psize_pick;
		logic [CFG_DATA_W-1:0] total_pick;
		int unsigned psize_list [16] = '{0, 1, 2, 3, 4, 5, 8, 9, 16, 17, 128, 129,
			255, 256, 257, 511};

		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_WRITE;
		req_bus.entry_index = '0;
		req_bus.entry_red = '0;
		req_bus.entry_green = '0;
		req_bus.entry_blue = '0;
		req_bus.data_byte = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_PALETTE_SIZE;
		cfg_bus.data = '0;

		psize_reg = PSIZE_RESET;
		total_reg = TOTAL_RESET;
		fmt_reg = 1'b0;
		parse_ph = PH_FLAG;
		bit_cnt = 4'd0;
		rep_acc = 8'd0;
		idx_acc = 8'd0;
		px_done = '0;
		foreach (colour_table[e]) colour_table[e] = '0;

		directed.push_back(request_row(REQ_WRITE, 8'd0, 24'h000000, 8'h00));
		directed.push_back(request_row(REQ_WRITE, 8'd255, 24'hFFFFFF, 8'h00));
		directed.push_back(request_row(REQ_WRITE, 8'd1, 24'h123456, 8'h00));
		// longest run: repeat count 255 split across three bytes
		directed.push_back(request_row(REQ_DATA, 8'd0, 24'h0, 8'hFF));
		directed.push_back(request_row(REQ_DATA, 8'd0, 24'h0, 8'hFF));
		directed.push_back(typed_row(request_row(REQ_DATA, 8'd0, 24'h0, 8'h80),
			24'hFFFFFF, 9'd256, 1'b0, 1'b0));
		directed.push_back(request_row(REQ_START, 8'd0, 24'h0, 8'h00));
		directed.push_back(setting_row(CFG_PALETTE_SIZE, 21'd2));
		directed.push_back(request_row(REQ_DATA, 8'd0, 24'h0, 8'h51));
		directed.push_back(setting_row(CFG_OUT_FORMAT, 21'd1));
		directed.push_back(request_row(REQ_DATA, 8'd0, 24'h0, 8'h40));
		directed.push_back(setting_row(CFG_OUT_FORMAT, 21'd0));
		// run of five cut to the three pixels of the image, tail of byte ignored
		directed.push_back(setting_row(CFG_PIXEL_TOTAL, 21'd3));
		directed.push_back(request_row(REQ_START, 8'd0, 24'h0, 8'h00));
		directed.push_back(request_row(REQ_DATA, 8'd0, 24'h0, 8'h82));
		directed.push_back(typed_row(request_row(REQ_DATA, 8'd0, 24'h0, 8'h7F),
			24'h123456, 9'd3, 1'b1, 1'b1));
		directed.push_back(request_row(REQ_DATA, 8'd0, 24'h0, 8'hFF));
		directed.push_back(request_row(REQ_UNUSED, 8'd7, 24'hABCDEF, 8'h00));
		directed.push_back(request_row(REQ_START, 8'd0, 24'h0, 8'h00));
		directed.push_back(request_row(REQ_DATA, 8'd0, 24'h0, 8'h00));
		directed.push_back(setting_row(CFG_PIXEL_TOTAL, 21'd0));
		directed.push_back(request_row(REQ_START, 8'd0, 24'h0, 8'h00));
		directed.push_back(request_row(REQ_DATA, 8'd0, 24'h0, 8'h00));
		directed.push_back(setting_row(CFG_PIXEL_TOTAL, 21'h100000));
		directed.push_back(setting_row(CFG_PALETTE_SIZE, 21'd0));
		directed.push_back(request_row(REQ_START, 8'd0, 24'h0, 8'h00));
		// index seven bits read at width 8, then the width drops to 1
		directed.push_back(request_row(REQ_DATA, 8'd0, 24'h0, 8'h00));
		directed.push_back(setting_row(CFG_PALETTE_SIZE, 21'd1));
		directed.push_back(request_row(REQ_DATA, 8'd0, 24'h0, 8'h80));
		directed.push_back(setting_row(CFG_PALETTE_SIZE, 21'd511));
		directed.push_back(setting_row(CFG_PALETTE_SIZE, 21'd3));
		directed.push_back(request_row(REQ_START, 8'd0, 24'h0, 8'h00));
		directed.push_back(request_row(REQ_DATA, 8'd0, 24'h0, 8'h69));
		directed.push_back(setting_row(CFG_PALETTE_SIZE, 21'd128));
		directed.push_back(request_row(REQ_START, 8'd0, 24'h0, 8'h00));
		directed.push_back(request_row(REQ_DATA, 8'd0, 24'h0, 8'h7F));
		// total lowered to the pixels already out
		directed.push_back(setting_row(CFG_PIXEL_TOTAL, 21'd1));
		directed.push_back(request_row(REQ_DATA, 8'd0, 24'h0, 8'h00));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// every entry gets a colour before any index can reach it
		for (int e = 0; e < 256; e++) begin
			rnd = $urandom();
			it = '{kind: REQ_WRITE, slot: e[7:0], red: rnd[7:0], green: rnd[15:8],
				blue: rnd[23:16], dbyte: rnd[31:24]};
			if ($urandom_range(0, 24) == 0) send_burst = !send_burst;
			send_req(it, 1'b0, no_run);
		end

		foreach (directed[k]) begin
			if (directed[k].is_setting) write_setting(directed[k].reg_idx, directed[k].reg_val);
			else send_req(directed[k].item, directed[k].typed, directed[k].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if ($urandom_range(0, 1) == 0)
				psize_pick = CFG_DATA_W'(psize_list[$urandom_range(0, 15)]);
			else
				psize_pick = CFG_DATA_W'($urandom_range(0, 511));
			case ($urandom_range(0, 11))
				0:       total_pick = 21'd0;
				1:       total_pick = 21'h100000;
				2, 3:    total_pick = CFG_DATA_W'($urandom_range(1, 8));
				4, 5, 6: total_pick = CFG_DATA_W'($urandom_range(9, 300));
				default: total_pick = CFG_DATA_W'($urandom_range(301, 3000));
			endcase
			if (ph == HOLD_PHASE) total_pick = 21'h100000;
			write_setting(CFG_PALETTE_SIZE, psize_pick);
			write_setting(CFG_PIXEL_TOTAL, total_pick);
			write_setting(CFG_OUT_FORMAT, CFG_DATA_W'($urandom_range(0, 1)));
			// now and then keep the half-parsed image across the new settings
			if ($urandom_range(0, 3) != 0 || ph == HOLD_PHASE) begin
				it = '{kind: REQ_START, slot: 8'd0, red: 8'd0, green: 8'd0, blue: 8'd0,
					dbyte: 8'd0};
				send_req(it, 1'b0, no_run);
			end
			if (ph == HOLD_PHASE) begin
				long_hold_req = 1'b1;
				send_burst = 1'b1;
			end
			repeat (PHASE_ITEMS) begin
				random_item(it);
				if (ph == HOLD_PHASE) it.kind = REQ_DATA;
				if ($urandom_range(0, 24) == 0) send_burst = !send_burst;
				send_req(it, 1'b0, no_run);
			end
		end

		wait_idle();

		$display("sent %0d requests: %0d image bytes, %0d palette writes, %0d register writes",
			items_sent, bytes_sent, writes_sent, settings_written);
		$display("checked %0d runs, %0d clipped, %0d completing an image",
			runs_checked, runs_clipped, images_done);
		if (fail_count == 0 && pending_runs.size() == 0)
			$display("rle_palette_image_decoder_core regression: pass");
		else
			$display("rle_palette_image_decoder_core regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
